// ===== rtl/utf8_byte_stream_decoder_macros.svh =====
// assertion macros for the utf8 byte stream decoder
// expects a clock i_clk and an active-low synchronous reset i_rst_n in scope
`ifndef UTF8_BYTE_STREAM_DECODER_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define UTF8D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder check failed");
// next-cycle implication
`define UTF8D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder check failed");
`else
`define UTF8D_ASSERT_NOW(label, ante, cons)
`define UTF8D_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/utf8d_pkg.sv =====
// shared types and constants of the utf8 byte stream decoder
// no dependencies
package utf8d_pkg;

    localparam int CODE_W        = 18;
    localparam int PAY_W         = 7;
    localparam int CONT_W        = 6;
    localparam int REM_W         = 3;
    localparam int CMD_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    // continuation bytes still expected after a lead
    localparam logic [REM_W-1:0] REM_NONE  = 3'd0;
    localparam logic [REM_W-1:0] REM_TWO   = 3'd1;
    localparam logic [REM_W-1:0] REM_THREE = 3'd2;
    localparam logic [REM_W-1:0] REM_FOUR  = 3'd3;
    localparam logic [REM_W-1:0] REM_FIVE  = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic              cut_off;
        logic              last;
    } t_out_item;

    typedef enum logic {
        KIND_LEAD,
        KIND_CONT
    } t_kind;

    // classified byte handed from front to back
    typedef struct packed {
        t_kind            kind;
        logic [PAY_W-1:0] bits;
        logic             emit;
        logic             cut;
        logic             last;
    } t_cmd;

endpackage

// ===== rtl/utf8d_fifo.sv =====
// small register fifo with show-ahead read, used between pipeline parts
// no dependencies
module utf8d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/utf8d_front.sv =====
// front part: tracks sequence position and classifies each byte
// depends on utf8d_pkg
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  t_in_item         i_item,
    output t_cmd             o_cmd,
    output logic [REM_W-1:0] o_rem
);

    logic [REM_W-1:0] r_rem, n_rem;
    logic [REM_W-1:0] rem_new;
    logic [PAY_W-1:0] bits;
    logic [7:0]       b;
    logic             done;

    assign b     = i_item.in_byte;
    assign o_rem = r_rem;

    always_comb begin
        rem_new = REM_NONE;
        bits    = '0;
        if (r_rem == REM_NONE) begin
            case (b) inside
                8'b0???????: begin
                    rem_new = REM_NONE;
                    bits    = b[PAY_W-1:0];
                end
                8'b110?????: begin
                    rem_new = REM_TWO;
                    bits    = {1'b0, b[5:0]};
                end
                8'b1110????: begin
                    rem_new = REM_THREE;
                    bits    = {2'b00, b[4:0]};
                end
                8'b11110???: begin
                    rem_new = REM_FOUR;
                end
                default: begin
                    rem_new = REM_FIVE;
                end
            endcase
        end else begin
            rem_new = r_rem - REM_W'(1);
            bits    = {1'b0, b[CONT_W-1:0]};
        end
        done       = (rem_new == REM_NONE);
        o_cmd.kind = (r_rem == REM_NONE) ? KIND_LEAD : KIND_CONT;
        o_cmd.bits = bits;
        o_cmd.emit = done || i_item.end_of_stream;
        o_cmd.cut  = !done && i_item.end_of_stream;
        o_cmd.last = i_item.end_of_stream;
        n_rem      = i_item.end_of_stream ? REM_NONE : rem_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= REM_NONE;
        end else if (i_take) begin
            r_rem <= n_rem;
        end
    end

endmodule

// ===== rtl/utf8d_back.sv =====
// back part: accumulates code point bits and forms results
// depends on utf8d_pkg
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic      i_clk,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_valid,
    output logic      o_cmd_pop,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_item o_res
);

    logic [CODE_W-1:0] r_acc, n_acc;

    always_comb begin
        if (i_cmd.kind == KIND_LEAD) begin
            n_acc = {{(CODE_W-PAY_W){1'b0}}, i_cmd.bits};
        end else begin
            n_acc = {r_acc[CODE_W-CONT_W-1:0], i_cmd.bits[CONT_W-1:0]};
        end
        o_cmd_pop        = i_cmd_valid && !(i_cmd.emit && i_res_full);
        o_res_push       = i_cmd_valid && i_cmd.emit && !i_res_full;
        o_res.code_point = i_cmd.cut ? '0 : n_acc;
        o_res.cut_off    = i_cmd.cut;
        o_res.last       = i_cmd.last;
    end

    // payload only, a lead always reloads it
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_acc <= n_acc;
        end
    end

endmodule

// ===== rtl/utf8_byte_stream_decoder.sv =====
// utf8 byte stream decoder: one byte per request, one code point per finished sequence, a cut-off result per cut one
// a result is registered in the command fifo and then in the output fifo before it is shown
// throughput: one byte per cycle while full is low, set by the combinational front classifier and back accumulator
// a result waits in the output fifo without stalling input until both fifos fill
// reset: synchronous active low, clears sequence position and empties both fifos
`include "utf8_byte_stream_decoder_macros.svh"
module utf8_byte_stream_decoder
    import utf8d_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int RES_DEPTH = RES_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // byte requests
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    // result requests
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    // front to back command queue
    t_cmd             front_cmd;
    t_cmd             back_cmd;
    logic             cmd_empty;
    logic             cmd_pop;
    logic [REM_W-1:0] front_rem;

    // back to output result queue
    t_out_item res_item;
    logic      res_push;
    logic      res_full;
    logic      in_take;

    // a byte is taken whenever the command queue has room
    assign in_take = push && !full;

    // front: sequence length tracking, byte classification
    utf8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_item  (i_in_item),
        .o_cmd   (front_cmd),
        .o_rem   (front_rem)
    );

    // decouples front from back so either can stall
    utf8d_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    // back: value accumulation, result formation
    utf8d_back u_back (
        .i_clk       (i_clk),
        .i_cmd       (back_cmd),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_item)
    );

    // output queue, head is shown while not empty
    utf8d_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

    // a cut-off result carries a zero value and closes the stream
    `UTF8D_ASSERT_NOW(a_cut_off_shape, !empty && o_out_item.cut_off,
        o_out_item.code_point == '0 && o_out_item.last)
    // after an end-of-stream byte the next byte is a lead
    `UTF8D_ASSERT_NEXT(a_eos_resets_front, in_take && i_in_item.end_of_stream,
        front_rem == REM_NONE)
    // back never offers a result the output queue cannot hold
    `UTF8D_ASSERT_NOW(a_no_res_overflow, res_push, !res_full)
    // nothing in flight and nothing taken means no result appears
    `UTF8D_ASSERT_NEXT(a_no_invented_result, cmd_empty && empty && !in_take, empty)

endmodule

// ===== tb/sv/tb_utf8_byte_stream_decoder.sv =====
// self-checking testbench for the utf8 byte stream decoder: a directed byte table, then random
// streams, checked against a cycle-free decoding predictor or, for pinned rows, typed-in results
// depends on utf8d_pkg and the utf8_byte_stream_decoder top level
module tb_utf8_byte_stream_decoder;
    import utf8d_pkg::*;

    // generous bound for about 900 byte requests with idling on both sides
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 850;
    localparam int TABLE_ROWS   = 25;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_MAX   = 10;

    // result taken from the table instead of the predictor
    localparam logic PIN  = 1'b1;
    localparam logic FREE = 1'b0;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop;
    t_out_item o_out_item;

    utf8_byte_stream_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    // one row of the directed stream: byte, end flag, and a typed-in result where pinned
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
        logic       pinned;
        t_out_item  want;
    } byte_row_t;

    // the directed stream
    byte_row_t stream_table [0:TABLE_ROWS-1] = '{
        // single-byte extremes, then a single byte closing a stream
        {8'h00, 1'b0, PIN,  18'h00000, 1'b0, 1'b0},
        {8'h7F, 1'b0, PIN,  18'h0007F, 1'b0, 1'b0},
        {8'h41, 1'b1, PIN,  18'h00041, 1'b0, 1'b1},
        // two-byte sequence with all payload bits set, end of stream on its final byte
        {8'hDF, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hBF, 1'b1, FREE, 18'h00000, 1'b0, 1'b0},
        // three-byte sequence, full payload
        {8'hEF, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hBF, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hBF, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        // four-byte sequence: lead payload dropped, value fills all 18 bits
        {8'hF7, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hBF, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hBF, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hBF, 1'b0, PIN,  18'h3FFFF, 1'b0, 1'b0},
        // stray continuation byte as lead opens a five-byte sequence, unchecked tails
        {8'h80, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'h3F, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'h00, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hC0, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'h7F, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        // 11111xxx lead, five bytes, only the last three tails survive
        {8'hFF, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hFF, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hFF, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hFF, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'hFF, 1'b0, PIN,  18'h3FFFF, 1'b0, 1'b0},
        // stream cut inside a three-byte sequence
        {8'hE0, 1'b0, FREE, 18'h00000, 1'b0, 1'b0},
        {8'h80, 1'b1, PIN,  18'h00000, 1'b1, 1'b1},
        // stream cut right on a four-byte lead
        {8'hF0, 1'b1, PIN,  18'h00000, 1'b1, 1'b1}
    };

    // predictor state: open sequence position and partial value
    logic [REM_W-1:0]  seq_left;
    logic [CODE_W-1:0] seq_value;

    // code points still owed by the block, oldest first
    t_out_item pending_code_points [$];

    int        fail_count;
    int        cycle_count;
    logic      no_idle;
    t_out_item oldest_code_point;

    // decode one accepted byte; returns 1 when the byte yields a result
    function automatic logic decode_byte(input t_in_item req, output t_out_item res);
        logic done;
        res = '0;
        if (seq_left == REM_NONE) begin
            // lead byte picks the sequence length and its payload
            casez (req.in_byte)
                8'b0???????: begin
                    seq_value = {10'd0, req.in_byte};
                    seq_left  = REM_NONE;
                end
                8'b110?????: begin
                    seq_value = {12'd0, req.in_byte[5:0]};
                    seq_left  = REM_TWO;
                end
                8'b1110????: begin
                    seq_value = {13'd0, req.in_byte[4:0]};
                    seq_left  = REM_THREE;
                end
                8'b11110???: begin
                    seq_value = '0;
                    seq_left  = REM_FOUR;
                end
                default: begin
                    // stray continuation byte or 11111xxx
                    seq_value = '0;
                    seq_left  = REM_FIVE;
                end
            endcase
        end else begin
            // tail byte: low six bits shift in, top bits fall off at 18
            seq_value = {seq_value[CODE_W-CONT_W-1:0], req.in_byte[CONT_W-1:0]};
            seq_left  = seq_left - REM_W'(1);
        end
        done = (seq_left == REM_NONE);
        if (done) begin
            res.code_point = seq_value;
            res.last       = req.end_of_stream;
        end else if (req.end_of_stream) begin
            // stream ended with the sequence still open
            res.cut_off = 1'b1;
            res.last    = 1'b1;
        end
        if (req.end_of_stream) begin
            seq_left  = REM_NONE;
            seq_value = '0;
        end
        return done || req.end_of_stream;
    endfunction

    // drive one byte request, idling first at random, and predict once it is taken
    task automatic send_request(input logic [7:0] b, input logic eos, input logic pinned,
                                input t_out_item want);
        t_in_item  req;
        t_out_item res;
        req.in_byte       = b;
        req.end_of_stream = eos;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 9) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= req;
        // hold the request until the block has room
        do @(posedge i_clk); while (full);
        if (decode_byte(req, res))
            pending_code_points.push_back(pinned ? want : res);
    endtask

    // free-running clock, period 2
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run bound
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: pop idles with a chance of about 9 in a hundred outside the calm stretch
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= no_idle || ($urandom_range(99) >= 9);
        end
    end

    // compare each taken result with the oldest owed code point
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_code_points.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: code_point %h cut_off %b last %b",
                             o_out_item.code_point, o_out_item.cut_off, o_out_item.last);
            end else begin
                oldest_code_point = pending_code_points.pop_front();
                if (o_out_item.code_point !== oldest_code_point.code_point
                        || o_out_item.cut_off !== oldest_code_point.cut_off
                        || o_out_item.last !== oldest_code_point.last) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch: want %h/%b/%b got %h/%b/%b",
                                 oldest_code_point.code_point, oldest_code_point.cut_off,
                                 oldest_code_point.last, o_out_item.code_point,
                                 o_out_item.cut_off, o_out_item.last);
                end
            end
        end
    end

    // stimulus
    initial begin
        int         random_sent;
        int         seq_len;
        int         k;
        logic [7:0] b;
        logic       eos;

        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_in_item   = '0;
        no_idle     = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        seq_left    = REM_NONE;
        seq_value   = '0;
        random_sent = 0;

        // reset held low, then released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed stream
        for (int i = 0; i < TABLE_ROWS; i++)
            send_request(stream_table[i].in_byte, stream_table[i].end_of_stream,
                         stream_table[i].pinned, stream_table[i].want);

        // random streams: mostly well-formed sequences with random payload, some noise
        while (random_sent < RANDOM_BYTES) begin
            // calm stretch with no idling on either side
            no_idle = (random_sent >= 300 && random_sent < 500);
            if ($urandom_range(99) < 80) begin
                seq_len = $urandom_range(5, 1);
                case (seq_len)
                    1: b = {1'b0, 7'($urandom)};
                    2: b = {3'b110, 5'($urandom)};
                    3: b = {4'b1110, 4'($urandom)};
                    4: b = {5'b11110, 3'($urandom)};
                    default: b = $urandom_range(1) ? {2'b10, 6'($urandom)}
                                                   : {5'b11111, 3'($urandom)};
                endcase
                for (k = 0; k < seq_len; k++) begin
                    if (k > 0)
                        // tails are unchecked, so now and then any byte stands in
                        b = ($urandom_range(9) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
                    // end of stream lands anywhere, cutting some sequences short
                    eos = ($urandom_range(29) == 0);
                    send_request(b, eos, FREE, '0);
                    random_sent++;
                end
            end else begin
                // noise byte
                eos = ($urandom_range(7) == 0);
                send_request(8'($urandom), eos, FREE, '0);
                random_sent++;
            end
        end
        no_idle = 1'b0;

        @(negedge i_clk);
        push <= 1'b0;

        // drain owed results, then keep watching for stray results
        while (pending_code_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_code_points.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
